// ===== rtl/irptm_pkg.sv =====
// Shared types, constants and the template ROM of the IR pulse template matcher.
package irptm_pkg;

    // Nominal template durations in microseconds
    localparam int unsigned LEAD_MARK_US  = 9000;
    localparam int unsigned LEAD_SPACE_US = 4200;
    localparam int unsigned SHORT_US      = 600;
    localparam int unsigned LONG_US       = 1800;

    // Widths fixed by the transaction fields
    localparam int unsigned TIME_W  = 16;
    localparam int unsigned POS_W   = 6;
    localparam int unsigned IDX_W   = 3;
    localparam int unsigned MASK_W  = 5;
    // Codes that have a hold mask bit
    localparam int unsigned MASK_CODES = 5;

    // Result action codes
    typedef enum logic [1:0] {
        ACT_NONE       = 2'd0,
        ACT_PRESS      = 2'd1,
        ACT_HOLD_START = 2'd2,
        ACT_HOLD_END   = 2'd3
    } t_action;

    // Rounded pair classified against the four template pair shapes
    typedef struct packed {
        logic lead;         // (lead mark, lead space)
        logic short_short;  // (short mark, short space)
        logic short_long;   // (short mark, long space)
        logic short_final;  // (short mark, zero space)
    } t_pair_class;

    // Result transaction
    typedef struct packed {
        logic             no_match;
        t_action          action;
        logic [IDX_W-1:0] code_index;
        logic             hit;
    } t_result;

    // Template ROM: bit k set means inner pair k+1 has a long space
    function automatic logic [63:0] code_long_bits(input int unsigned code);
        logic [63:0] bits;
        case (code)
            0:       bits = 64'h0000_0000_F609_DF20;
            1:       bits = 64'h0000_0000_EE11_DF20;
            2:       bits = 64'h0000_0000_E01F_DF20;
            3:       bits = 64'h0000_0000_E916_DF20;
            4:       bits = 64'h0000_0000_E817_DF20;
            default: bits = 64'h0;
        endcase
        return bits;
    endfunction

endpackage

// ===== rtl/irptm_pair_class.sv =====
// Rounds a mark/space pair to the time quantum and classifies it by template shape.
module irptm_pair_class
    import irptm_pkg::*;
#(
    parameter int unsigned QUANTUM_US = 600
) (
    input  logic [TIME_W-1:0] i_mark,
    input  logic [TIME_W-1:0] i_space,
    input  logic              i_ends,
    output t_pair_class       o_class
);

    localparam int unsigned SUM_W = TIME_W + 2;
    localparam int unsigned HALF  = QUANTUM_US / 2;

    // A nominal value can only be hit when it is a multiple of the quantum
    localparam bit LEAD_MARK_OK  = (LEAD_MARK_US % QUANTUM_US) == 0;
    localparam bit LEAD_SPACE_OK = (LEAD_SPACE_US % QUANTUM_US) == 0;
    localparam bit SHORT_OK      = (SHORT_US % QUANTUM_US) == 0;
    localparam bit LONG_OK       = (LONG_US % QUANTUM_US) == 0;

    logic [SUM_W-1:0] mark_bias;
    logic [SUM_W-1:0] space_bias;
    logic m_lead, m_short;
    logic s_lead, s_short, s_long, s_zero;

    // value rounds to T when T <= value + Q/2 < T + Q
    assign mark_bias  = {2'b00, i_mark} + SUM_W'(HALF);
    assign space_bias = {2'b00, i_space} + SUM_W'(HALF);

    assign m_lead  = LEAD_MARK_OK && (mark_bias >= SUM_W'(LEAD_MARK_US))
                     && (mark_bias < SUM_W'(LEAD_MARK_US + QUANTUM_US));
    assign m_short = SHORT_OK && (mark_bias >= SUM_W'(SHORT_US))
                     && (mark_bias < SUM_W'(SHORT_US + QUANTUM_US));

    // Space is forced to zero on the pair that ends the frame
    assign s_lead  = !i_ends && LEAD_SPACE_OK && (space_bias >= SUM_W'(LEAD_SPACE_US))
                     && (space_bias < SUM_W'(LEAD_SPACE_US + QUANTUM_US));
    assign s_short = !i_ends && SHORT_OK && (space_bias >= SUM_W'(SHORT_US))
                     && (space_bias < SUM_W'(SHORT_US + QUANTUM_US));
    assign s_long  = !i_ends && LONG_OK && (space_bias >= SUM_W'(LONG_US))
                     && (space_bias < SUM_W'(LONG_US + QUANTUM_US));
    assign s_zero  = i_ends || (space_bias < SUM_W'(QUANTUM_US));

    assign o_class.lead        = m_lead && s_lead;
    assign o_class.short_short = m_short && s_short;
    assign o_class.short_long  = m_short && s_long;
    assign o_class.short_final = m_short && s_zero;

endmodule

// ===== rtl/irptm_slot.sv =====
// One template slot: position register and compare against its ROM pair.
module irptm_slot
    import irptm_pkg::*;
#(
    parameter int unsigned CODE_ID    = 0,
    parameter int unsigned CODE_PAIRS = 34
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_step,
    input  logic        i_ends,
    input  logic        i_frame_matched,
    input  t_pair_class i_class,
    output logic        o_final
);

    localparam logic [63:0] LONG_BITS = code_long_bits(CODE_ID);

    logic [POS_W-1:0] r_pos;
    logic [POS_W-1:0] n_pos;
    logic             in_range;
    logic             at_final;
    logic             inner_long;
    logic             inner_match;

    // Template pair at the current position
    assign in_range   = {1'b0, r_pos} < (POS_W + 1)'(CODE_PAIRS);
    assign at_final   = {1'b0, r_pos} >= (POS_W + 1)'(CODE_PAIRS - 1);
    assign inner_long = LONG_BITS[r_pos - POS_W'(1)];

    always_comb begin
        inner_match = 1'b0;
        o_final     = 1'b0;
        if (in_range) begin
            if (r_pos == '0) begin
                inner_match = i_class.lead;
            end else if (at_final) begin
                o_final = i_class.short_final;
            end else begin
                inner_match = inner_long ? i_class.short_long : i_class.short_short;
            end
        end
    end

    // Advance on match, fall back to zero otherwise or at frame end; frozen after a hit
    always_comb begin
        n_pos = r_pos;
        if (i_step) begin
            if (i_ends) begin
                n_pos = '0;
            end else if (!i_frame_matched) begin
                n_pos = inner_match ? r_pos + POS_W'(1) : '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= '0;
        end else begin
            r_pos <= n_pos;
        end
    end

endmodule

// ===== rtl/ir_pulse_template_matcher.sv =====
// Top level of the IR pulse template matcher: stream ports, frame control, result register.
//
// Each input transaction carries one IR mark/space pair in microseconds and yields
// exactly one result transaction. Both durations are rounded to the nearest
// multiple of QUANTUM_US and compared in parallel against NUM_CODES fixed ROM
// templates, each tracking its own position. The lowest template that reaches
// its final pair reports a hit; hold codes (hold_code_mask) toggle a hold state
// and report start/end hold, other codes report press-and-release. A frame ends
// on tlast or on its MAX_PAIRS-th pair. A pair passes from the input register through
// the parallel comparator bank into the result register, and a new pair is accepted
// every cycle unless m_axis_tready holds a full result register back.
// The hold mask may be rewritten only while no pair is in flight.
module ir_pulse_template_matcher
    import irptm_pkg::*;
#(
    parameter int unsigned NUM_CODES  = 5,
    parameter int unsigned CODE_PAIRS = 34,
    parameter int unsigned MAX_PAIRS  = 50,
    parameter int unsigned QUANTUM_US = 600
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    // configuration
    input  logic              i_cfg_we,
    input  logic [MASK_W-1:0] i_cfg_wdata,   // hold_code_mask
    // pair stream in
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    input  logic [31:0]       s_axis_tdata,  // [15:0] mark_time, [31:16] space_time
    input  logic              s_axis_tlast,  // last_pair
    // result stream out
    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    output logic [7:0]        m_axis_tdata   // [0] hit, [3:1] code_index, [5:4] action,
                                             // [6] no_match, [7] zero
);

    localparam int unsigned CNT_W = POS_W;

    // Input register
    logic              r_in_valid;
    logic [TIME_W-1:0] r_mark;
    logic [TIME_W-1:0] r_space;
    logic              r_last;

    // Frame and hold state
    logic [CNT_W-1:0]  r_pair_count;
    logic              r_frame_matched;
    logic              r_holding;
    logic [MASK_W-1:0] r_hold_mask;

    // Result register
    logic              r_out_valid;
    t_result           r_out;

    logic                 step;
    logic                 ends;
    t_pair_class          pair_class;
    logic [NUM_CODES-1:0] slot_final;
    t_result              n_out;
    logic                 n_holding;
    logic                 hit;
    int unsigned          hit_code;

    // Handshake: the result register frees up as soon as it is taken
    assign step          = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || step;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {1'b0, r_out};

    // Frame ends on tlast or on the last allowed pair
    assign ends = r_last || (({1'b0, r_pair_count} + (CNT_W + 1)'(1)) >= (CNT_W + 1)'(MAX_PAIRS));

    irptm_pair_class #(
        .QUANTUM_US(QUANTUM_US)
    ) u_class (
        .i_mark (r_mark),
        .i_space(r_space),
        .i_ends (ends),
        .o_class(pair_class)
    );

    // Template slots
    for (genvar g = 0; g < NUM_CODES; g++) begin : g_slot
        irptm_slot #(
            .CODE_ID   (g),
            .CODE_PAIRS(CODE_PAIRS)
        ) u_slot (
            .i_clk          (i_clk),
            .i_rst_n        (i_rst_n),
            .i_step         (step),
            .i_ends         (ends),
            .i_frame_matched(r_frame_matched),
            .i_class        (pair_class),
            .o_final        (slot_final[g])
        );
    end

    // Lowest matching template wins
    always_comb begin
        hit      = 1'b0;
        hit_code = 0;
        for (int j = NUM_CODES - 1; j >= 0; j--) begin
            if (slot_final[j]) begin
                hit      = 1'b1;
                hit_code = j;
            end
        end
        hit = hit && !r_frame_matched;
    end

    // Result and hold update
    always_comb begin
        n_out      = '0;
        n_holding  = r_holding;
        if (hit) begin
            n_out.hit        = 1'b1;
            n_out.code_index = IDX_W'(hit_code);
            if (hit_code < MASK_CODES && r_hold_mask[hit_code[2:0]]) begin
                n_out.action = r_holding ? ACT_HOLD_END : ACT_HOLD_START;
                n_holding    = !r_holding;
            end else begin
                n_out.action = ACT_PRESS;
                n_holding    = 1'b0;
            end
        end
        n_out.no_match = ends && !r_frame_matched && !hit;
    end

    // Registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid      <= 1'b0;
            r_out_valid     <= 1'b0;
            r_pair_count    <= '0;
            r_frame_matched <= 1'b0;
            r_holding       <= 1'b0;
            r_hold_mask     <= MASK_W'(12);
        end else begin
            if (i_cfg_we) begin
                r_hold_mask <= i_cfg_wdata;
            end
            if (s_axis_tvalid && s_axis_tready) begin
                r_in_valid <= 1'b1;
            end else if (step) begin
                r_in_valid <= 1'b0;
            end
            if (step) begin
                r_out_valid     <= 1'b1;
                r_holding       <= n_holding;
                r_pair_count    <= ends ? '0 : r_pair_count + CNT_W'(1);
                r_frame_matched <= ends ? 1'b0 : (r_frame_matched || hit);
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_mark  <= s_axis_tdata[15:0];
            r_space <= s_axis_tdata[31:16];
            r_last  <= s_axis_tlast;
        end
        if (step) begin
            r_out <= n_out;
        end
    end

    // Checks
    a_hit_no_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && r_out.hit |-> !r_out.no_match)
        else $error("hit and no_match in the same result");

    a_idle_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !r_out.hit |-> r_out.code_index == '0 && r_out.action == ACT_NONE)
        else $error("code or action set without a hit");

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        {1'b0, r_pair_count} < (CNT_W + 1)'(MAX_PAIRS))
        else $error("pair count beyond frame limit");

    a_result_after_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        step |=> m_axis_tvalid)
        else $error("processed pair produced no result");

endmodule

// ===== sim/tb.sv =====
// Self-checking testbench for the IR pulse template matcher stream block.
module tb;
    import irptm_pkg::*;

    localparam int NUM_CODES    = 5;
    localparam int CODE_PAIRS   = 34;
    localparam int MAX_PAIRS    = 50;
    localparam int QUANTUM_US   = 600;
    localparam int LIMIT_CYCLES = 200000;
    localparam int DRAIN_CYCLES = 20;
    localparam int STALL_CYCLES = 150;
    localparam logic [MASK_W-1:0] MASK_AFTER_RESET = 5'd12;

    // Template space pattern: bit k set means inner pair k+1 has a long space
    localparam logic [NUM_CODES-1:0][31:0] LONG_SPACE_BITS = {
        32'hE817_DF20, 32'hE916_DF20, 32'hE01F_DF20, 32'hEE11_DF20, 32'hF609_DF20
    };

    localparam t_result QUIET    = '0;
    localparam t_result NO_MATCH = '{no_match: 1'b1, action: ACT_NONE,
                                     code_index: 3'd0, hit: 1'b0};

    typedef enum int {
        FR_CLEAN,        // template frame, tlast on the final pair
        FR_EARLY_FINAL,  // final pair with near-zero space before tlast, then trailing pairs
        FR_BROKEN,       // template frame with one corrupted pair
        FR_NOISE,        // random pairs
        FR_RUNAWAY       // no tlast: frame closes on the pair count
    } t_frame_kind;

    typedef struct {
        logic [15:0] mark;
        logic [15:0] space;
        logic        last;
        bit          known;
        t_result     want;
    } t_pair_row;

    logic              i_clk         = 1'b0;
    logic              i_rst_n       = 1'b0;
    logic              i_cfg_we      = 1'b0;
    logic [MASK_W-1:0] i_cfg_wdata   = '0;   // hold_code_mask
    logic              s_axis_tvalid = 1'b0;
    logic              s_axis_tready;
    logic [31:0]       s_axis_tdata  = '0;   // [15:0] mark_time, [31:16] space_time
    logic              s_axis_tlast  = 1'b0; // last_pair
    logic              m_axis_tvalid;
    logic              m_axis_tready = 1'b0;
    logic [7:0]        m_axis_tdata;         // [0] hit, [3:1] code_index, [5:4] action,
                                             // [6] no_match, [7] zero

    ir_pulse_template_matcher DUT (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tlast (s_axis_tlast),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata)
    );

    // Predicted matcher state
    logic [5:0]        code_pos [NUM_CODES];
    logic              frame_done;
    logic              hold_active;
    logic [5:0]        frame_pairs;
    logic [MASK_W-1:0] hold_mask;

    // Outcomes still owed by the block, oldest first
    t_result pair_outcomes_q [$];

    int pairs_sent        = 0;
    int frames_closed     = 0;
    int press_hits        = 0;
    int hold_starts       = 0;
    int hold_ends         = 0;
    int unmatched_frames  = 0;
    int mismatches        = 0;
    int send_idle_pct     = 27;
    int recv_idle_pct     = 68;
    int long_stall_cycles = 0;
    int cycle_count       = 0;

    initial begin : clock_gen
        forever #5 i_clk = ~i_clk;
    end

    function automatic int unsigned round_to_quantum(input logic [15:0] us);
        int unsigned v;
        v = us;
        return ((v + QUANTUM_US / 2) / QUANTUM_US) * QUANTUM_US;
    endfunction

    function automatic void template_pair(input int code, input int pos,
                                          output int unsigned mark, output int unsigned space);
        if (pos == 0) begin
            mark  = LEAD_MARK_US;
            space = LEAD_SPACE_US;
        end else if (pos >= CODE_PAIRS - 1) begin
            mark  = SHORT_US;
            space = 0;
        end else begin
            mark  = SHORT_US;
            space = LONG_SPACE_BITS[code][pos-1] ? LONG_US : SHORT_US;
        end
    endfunction

    function automatic void clear_frame();
        foreach (code_pos[j]) code_pos[j] = '0;
        frame_done  = 1'b0;
        frame_pairs = '0;
    endfunction

    // Advance the predicted state by one pair and return the outcome it yields
    function automatic t_result score_pair(input logic [15:0] mark, input logic [15:0] space,
                                           input logic last);
        t_result     r;
        logic        ends;
        logic        found;
        int unsigned qm, qs, tm, ts;
        r     = QUIET;
        found = 1'b0;
        ends  = last || (int'(frame_pairs) + 1 >= MAX_PAIRS);
        if (!frame_done) begin
            qm = round_to_quantum(mark);
            qs = ends ? 0 : round_to_quantum(space);
            for (int j = 0; j < NUM_CODES; j++) begin
                if (!found) begin
                    if (code_pos[j] >= CODE_PAIRS) begin
                        code_pos[j] = '0;
                    end else begin
                        template_pair(j, int'(code_pos[j]), tm, ts);
                        if (qm == tm && qs == ts && ts == 0) begin
                            // lowest completed template wins the frame
                            found        = 1'b1;
                            frame_done   = 1'b1;
                            r.hit        = 1'b1;
                            r.code_index = 3'(j);
                            if (hold_mask[j]) begin
                                r.action    = hold_active ? ACT_HOLD_END : ACT_HOLD_START;
                                hold_active = !hold_active;
                            end else begin
                                r.action    = ACT_PRESS;
                                hold_active = 1'b0;
                            end
                        end else if (qm == tm && qs == ts) begin
                            code_pos[j] = code_pos[j] + 6'd1;
                        end else begin
                            code_pos[j] = '0;
                        end
                    end
                end
            end
        end
        if (ends) begin
            if (!frame_done) r.no_match = 1'b1;
            frames_closed++;
            clear_frame();
        end else begin
            frame_pairs = frame_pairs + 6'd1;
        end
        return r;
    endfunction

    // A duration that rounds to the nominal value t
    function automatic logic [15:0] jitter_us(input int unsigned t);
        if (t == 0) return 16'($urandom_range(0, QUANTUM_US / 2 - 1));
        return 16'(t - QUANTUM_US / 2 + $urandom_range(0, QUANTUM_US - 1));
    endfunction

    // One input transaction; valid stays up into the next call unless a gap is drawn
    task automatic send_pair(input logic [15:0] mark, input logic [15:0] space,
                             input logic last, input bit known, input t_result known_want);
        t_result want;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {space, mark};
        s_axis_tlast  <= last;
        do @(posedge i_clk); while (!s_axis_tready);
        want = score_pair(mark, space, last);
        if (known) want = known_want;
        pair_outcomes_q.push_back(want);
        pairs_sent++;
        if (want.hit) begin
            case (want.action)
                ACT_PRESS:      press_hits++;
                ACT_HOLD_START: hold_starts++;
                default:        hold_ends++;
            endcase
        end
        if (want.no_match) unmatched_frames++;
        if ($urandom_range(0, 99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(0, 99) < send_idle_pct);
        end
    endtask

    task automatic send_plain(input logic [15:0] mark, input logic [15:0] space,
                              input logic last);
        send_pair(mark, space, last, 1'b0, QUIET);
    endtask

    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        while (pair_outcomes_q.size() != 0) @(posedge i_clk);
    endtask

    // Mask write only with nothing in flight
    task automatic set_hold_mask(input logic [MASK_W-1:0] value);
        wait_idle();
        repeat (4) @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        hold_mask = value;
        i_cfg_we  <= 1'b0;
    endtask

    task automatic send_frame(input t_frame_kind kind, input int code);
        int unsigned tm, ts;
        int          cut, n;
        // close whatever frame is still open
        if (frame_pairs != 6'd0) send_plain(16'($urandom), 16'($urandom), 1'b1);
        if (kind == FR_NOISE) begin
            n = $urandom_range(1, 60);
            for (int i = 0; i < n; i++) send_plain(16'($urandom), 16'($urandom), i == n - 1);
        end else begin
            cut = (kind == FR_BROKEN) ? int'($urandom_range(0, CODE_PAIRS - 1)) : -1;
            for (int p = 0; p < CODE_PAIRS - 1; p++) begin
                template_pair(code, p, tm, ts);
                if (p != cut) begin
                    send_plain(jitter_us(tm), jitter_us(ts), 1'b0);
                end else if ($urandom_range(0, 1) == 1) begin
                    send_plain(16'($urandom), jitter_us(ts), 1'b0);
                end else begin
                    send_plain(jitter_us(tm), jitter_us(ts == LONG_US ? SHORT_US : LONG_US),
                               1'b0);
                end
            end
            template_pair(code, CODE_PAIRS - 1, tm, ts);
            case (kind)
                FR_EARLY_FINAL: begin
                    // near-zero space completes the template before tlast
                    send_plain(jitter_us(tm), jitter_us(0), 1'b0);
                    n = $urandom_range(0, 4);
                    repeat (n) send_plain(16'($urandom), 16'($urandom), 1'b0);
                    send_plain(16'($urandom), 16'($urandom), 1'b1);
                end
                FR_RUNAWAY: begin
                    do send_plain(jitter_us(SHORT_US), jitter_us(SHORT_US), 1'b0);
                    while (frame_pairs != 6'd0);
                end
                default: begin
                    if (cut == CODE_PAIRS - 1) begin
                        send_plain(jitter_us(tm), jitter_us(LONG_US), 1'b0);
                    end else begin
                        send_plain(jitter_us(tm), 16'($urandom), 1'b1);
                    end
                end
            endcase
        end
    endtask

    task automatic run_phase(input int send_pct, input int recv_pct, input int pairs,
                             input logic [MASK_W-1:0] mask, input bit pressure);
        int          start, code, last_code, roll, frame_no;
        t_frame_kind kind;
        set_hold_mask(mask);
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        start         = pairs_sent;
        last_code     = 0;
        frame_no      = 0;
        while (pairs_sent - start < pairs) begin
            // repeats of one code exercise hold toggling
            code = ($urandom_range(0, 99) < 40) ? last_code
                                                : int'($urandom_range(0, NUM_CODES - 1));
            last_code = code;
            roll = $urandom_range(0, 99);
            kind = roll < 40 ? FR_CLEAN :
                   roll < 55 ? FR_EARLY_FINAL :
                   roll < 70 ? FR_BROKEN :
                   roll < 85 ? FR_NOISE : FR_RUNAWAY;
            send_frame(kind, code);
            frame_no++;
            if (pressure && frame_no == 1) long_stall_cycles = STALL_CYCLES;
            if (pressure && frame_no == 4) wait_idle();
        end
    endtask

    // Result side: random ready, or one long hold-off on request
    initial begin : result_sink
        forever begin
            @(posedge i_clk);
            if (long_stall_cycles > 0) begin
                m_axis_tready <= 1'b0;
                repeat (long_stall_cycles) @(posedge i_clk);
                long_stall_cycles = 0;
            end else begin
                m_axis_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
            end
        end
    end

    task automatic report_field(input string field, input logic [7:0] want,
                                input logic [7:0] got);
        $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, want, got);
        mismatches++;
    endtask

    // Compare each result transaction with the oldest outcome owed
    always @(posedge i_clk) begin : result_check
        t_result got, want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got = t_result'(m_axis_tdata[6:0]);
            if (pair_outcomes_q.size() == 0) begin
                $display("%0t: stray result, expected none, got %h", $time, m_axis_tdata);
                mismatches++;
            end else begin
                want = pair_outcomes_q.pop_front();
                if (got.hit !== want.hit)
                    report_field("hit", 8'(want.hit), 8'(got.hit));
                if (got.code_index !== want.code_index)
                    report_field("code_index", 8'(want.code_index), 8'(got.code_index));
                if (got.action !== want.action)
                    report_field("action", 8'(want.action), 8'(got.action));
                if (got.no_match !== want.no_match)
                    report_field("no_match", 8'(want.no_match), 8'(got.no_match));
                if (m_axis_tdata[7] !== 1'b0)
                    report_field("pad bit", 8'd0, 8'(m_axis_tdata[7]));
            end
        end
    end

    initial begin : watchdog
        while (cycle_count < LIMIT_CYCLES) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("%0t: run did not finish within %0d cycles, %0d results outstanding",
                 $time, LIMIT_CYCLES, pair_outcomes_q.size());
        $display("FAILURE");
        $finish;
    end

    initial begin : stimulus
        t_pair_row directed_rows [$];
        clear_frame();
        hold_active = 1'b0;
        hold_mask   = MASK_AFTER_RESET;

        // extremes, rounding edges and frame ends; no row here can complete a template
        directed_rows.push_back('{16'd0,     16'd0,     1'b1, 1'b1, NO_MATCH});
        directed_rows.push_back('{16'hFFFF,  16'hFFFF,  1'b0, 1'b1, QUIET});
        directed_rows.push_back('{16'hFFFF,  16'hFFFF,  1'b1, 1'b1, NO_MATCH});
        directed_rows.push_back('{16'd9000,  16'd4200,  1'b0, 1'b1, QUIET});
        directed_rows.push_back('{16'd600,   16'd600,   1'b0, 1'b1, QUIET});
        directed_rows.push_back('{16'd600,   16'd1800,  1'b0, 1'b0, QUIET});
        directed_rows.push_back('{16'd8700,  16'd3900,  1'b0, 1'b0, QUIET});
        directed_rows.push_back('{16'd8700,  16'd3900,  1'b0, 1'b0, QUIET});
        directed_rows.push_back('{16'd8700,  16'd4499,  1'b0, 1'b0, QUIET});
        directed_rows.push_back('{16'd899,   16'd899,   1'b0, 1'b0, QUIET});
        directed_rows.push_back('{16'd8699,  16'd4200,  1'b1, 1'b1, NO_MATCH});
        directed_rows.push_back('{16'd300,   16'd300,   1'b1, 1'b1, NO_MATCH});
        directed_rows.push_back('{16'd299,   16'd0,     1'b1, 1'b1, NO_MATCH});
        directed_rows.push_back('{16'd0,     16'hFFFF,  1'b0, 1'b1, QUIET});
        directed_rows.push_back('{16'hFFFF,  16'd0,     1'b1, 1'b1, NO_MATCH});

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed_rows[i]) begin
            send_pair(directed_rows[i].mark, directed_rows[i].space, directed_rows[i].last,
                      directed_rows[i].known, directed_rows[i].want);
        end

        run_phase(27, 68, 300, 5'd31, 1'b0);
        run_phase(68, 27, 300, 5'd0, 1'b0);
        run_phase(0, 0, 250, 5'($urandom), 1'b1);
        run_phase(0, 0, 250, 5'($urandom), 1'b0);

        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Sent %0d pairs over %0d frames: %0d press, %0d hold start, %0d hold end",
                 pairs_sent, frames_closed, press_hits, hold_starts, hold_ends);
        $display("%0d frames closed without a template; hold masks 12, 31, 0 and two random",
                 unmatched_frames);
        if (mismatches == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/irptm_pkg.sv
rtl/irptm_pair_class.sv
rtl/irptm_slot.sv
rtl/ir_pulse_template_matcher.sv
sim/tb.sv
